// ===== design/sspr_pkg.sv =====
// Package for the servo status packet receiver.
// Holds the queue item type, result and reject codes, header constants and the CRC step.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package sspr_pkg;

  // Header bytes and fixed packet values
  localparam logic [7:0] HDR_FF      = 8'hFF;
  localparam logic [7:0] HDR_FD      = 8'hFD;
  localparam logic [7:0] HDR_00      = 8'h00;
  localparam logic [7:0] ANY_ID      = 8'hFE;
  localparam logic [7:0] STATUS_INST = 8'h55;
  localparam logic [15:0] CRC_POLY   = 16'h8005;
  localparam logic [15:0] LEN_EXTRA  = 16'd4;

  // Queue depth between front and back
  localparam int QDEPTH = 2;
  localparam int QPW    = $clog2(QDEPTH);

  // Result kinds
  localparam logic [1:0] KIND_PARAM  = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  // Reject reasons
  localparam logic [2:0] RSN_NONE    = 3'd0;
  localparam logic [2:0] RSN_HEADER  = 3'd1;
  localparam logic [2:0] RSN_ID      = 3'd2;
  localparam logic [2:0] RSN_LENGTH  = 3'd3;
  localparam logic [2:0] RSN_INSTR   = 3'd4;
  localparam logic [2:0] RSN_CRC     = 3'd5;
  localparam logic [2:0] RSN_TIMEOUT = 3'd6;

  // Config register indexes
  localparam logic CFG_EXPECTED_ID  = 1'b0;
  localparam logic CFG_PARAM_COUNT  = 1'b1;

  // One classified beat as it travels from front to back
  typedef struct packed {
    logic       timeout;
    logic [7:0] data;
    logic       is_ff;
    logic       is_fd;
    logic       is_00;
    logic       id_ok;
    logic       len_lo_ok;
    logic       len_hi_ok;
    logic       instr_ok;
  } item_t;

  // CRC-16, poly 0x8005, MSB first, one byte
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/sspr_front.sv =====
// Front of the receiver: holds the config registers and classifies each input beat.
// Uses sspr_pkg; feeds sspr_queue.
`timescale 1ns / 1ps
`default_nettype none

module sspr_front
  import sspr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        action,
  input  wire logic [7:0]  rx_byte,
  output item_t            item,
  output logic [15:0]      param_count
);

  logic [7:0]  expected_id;
  logic [15:0] exp_len;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_id <= ANY_ID;
      param_count <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EXPECTED_ID: expected_id <= cfg_data[7:0];
        CFG_PARAM_COUNT: param_count <= cfg_data;
        default: ;
      endcase
    end
  end

  assign exp_len = param_count + LEN_EXTRA;

  // Stateless byte checks
  always_comb begin
    item.timeout   = action;
    item.data      = rx_byte;
    item.is_ff     = (rx_byte == HDR_FF);
    item.is_fd     = (rx_byte == HDR_FD);
    item.is_00     = (rx_byte == HDR_00);
    item.id_ok     = (expected_id == ANY_ID) || (expected_id == rx_byte);
    item.len_lo_ok = (rx_byte == exp_len[7:0]);
    item.len_hi_ok = (rx_byte == exp_len[15:8]);
    item.instr_ok  = (rx_byte == STATUS_INST);
  end

endmodule

`default_nettype wire

// ===== design/sspr_queue.sv =====
// Short queue between front and back of the receiver.
// Uses sspr_pkg for the item type and depth.
`timescale 1ns / 1ps
`default_nettype none

module sspr_queue
  import sspr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t push_item,
  output logic       full,
  input  wire logic  pop,
  output logic       avail,
  output item_t      head
);

  item_t            mem [QDEPTH];
  logic [QPW-1:0]   wr_ptr;
  logic [QPW-1:0]   rd_ptr;
  logic [QPW:0]     count;

  localparam logic [QPW:0]   DEPTH_C = (QPW+1)'(QDEPTH);
  localparam logic [QPW-1:0] LAST_C  = QPW'(QDEPTH - 1);

  assign full  = (count == DEPTH_C);
  assign avail = (count != '0);
  assign head  = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_C) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_C) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !avail))
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= DEPTH_C)
    else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

// ===== design/sspr_back.sv =====
// Back of the receiver: packet state machine, running CRC and the result register.
// Uses sspr_pkg; takes classified beats from sspr_queue.
`timescale 1ns / 1ps
`default_nettype none

module sspr_back
  import sspr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [15:0] param_count,
  input  wire logic        avail,
  input  wire item_t       head,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       kind,
  output logic [7:0]       param_byte,
  output logic [15:0]      param_index,
  output logic [7:0]       sender_id,
  output logic [7:0]       device_error,
  output logic [2:0]       reject_reason
);

  localparam logic [3:0] PH_H0    = 4'd0;
  localparam logic [3:0] PH_H1    = 4'd1;
  localparam logic [3:0] PH_H2    = 4'd2;
  localparam logic [3:0] PH_H3    = 4'd3;
  localparam logic [3:0] PH_ID    = 4'd4;
  localparam logic [3:0] PH_LEN1  = 4'd5;
  localparam logic [3:0] PH_LEN2  = 4'd6;
  localparam logic [3:0] PH_INSTR = 4'd7;
  localparam logic [3:0] PH_ERR   = 4'd8;
  localparam logic [3:0] PH_PARAM = 4'd9;
  localparam logic [3:0] PH_CRC1  = 4'd10;
  localparam logic [3:0] PH_CRC2  = 4'd11;

  logic [3:0]  phase, phase_next;
  logic [15:0] running_crc, running_crc_next;
  logic [15:0] param_counter, param_counter_next;
  logic [7:0]  received_id, received_id_next;
  logic [7:0]  error_byte, error_byte_next;
  logic [7:0]  crc_low_byte, crc_low_byte_next;

  logic        res_valid;
  logic [1:0]  res_kind;
  logic [7:0]  res_pbyte;
  logic [15:0] res_pidx;
  logic [7:0]  res_sid;
  logic [7:0]  res_err;
  logic [2:0]  res_reason;
  logic        finish_now;
  logic        hdr_ok;
  logic [15:0] crc_upd;
  logic [15:0] cnt_inc;

  // Take a beat whenever the result register is free or draining
  assign pop     = avail && (!out_valid || out_ready);
  assign crc_upd = crc_step(running_crc, head.data);
  assign cnt_inc = param_counter + 16'd1;

  // Header byte check for the current header position
  always_comb begin
    case (phase)
      PH_H0, PH_H1: hdr_ok = head.is_ff;
      PH_H2:        hdr_ok = head.is_fd;
      PH_H3:        hdr_ok = head.is_00;
      default:      hdr_ok = 1'b0;
    endcase
  end

  // Packet state machine
  always_comb begin
    phase_next         = phase;
    running_crc_next   = running_crc;
    param_counter_next = param_counter;
    received_id_next   = received_id;
    error_byte_next    = error_byte;
    crc_low_byte_next  = crc_low_byte;
    res_valid          = 1'b0;
    res_kind           = KIND_REJECT;
    res_pbyte          = '0;
    res_pidx           = '0;
    res_sid            = received_id;
    res_err            = error_byte;
    res_reason         = RSN_NONE;
    finish_now         = 1'b0;

    if (head.timeout) begin
      finish_now = 1'b1;
      res_reason = RSN_TIMEOUT;
    end else begin
      case (phase)
        PH_H0, PH_H1, PH_H2, PH_H3: begin
          if (!hdr_ok) begin
            finish_now = 1'b1;
            res_reason = RSN_HEADER;
          end else begin
            running_crc_next = crc_upd;
            phase_next       = phase + 4'd1;
          end
        end
        PH_ID: begin
          if (!head.id_ok) begin
            finish_now = 1'b1;
            res_sid    = head.data;
            res_reason = RSN_ID;
          end else begin
            received_id_next = head.data;
            running_crc_next = crc_upd;
            phase_next       = PH_LEN1;
          end
        end
        PH_LEN1: begin
          if (!head.len_lo_ok) begin
            finish_now = 1'b1;
            res_reason = RSN_LENGTH;
          end else begin
            running_crc_next = crc_upd;
            phase_next       = PH_LEN2;
          end
        end
        PH_LEN2: begin
          if (!head.len_hi_ok) begin
            finish_now = 1'b1;
            res_reason = RSN_LENGTH;
          end else begin
            running_crc_next = crc_upd;
            phase_next       = PH_INSTR;
          end
        end
        PH_INSTR: begin
          if (!head.instr_ok) begin
            finish_now = 1'b1;
            res_reason = RSN_INSTR;
          end else begin
            running_crc_next = crc_upd;
            phase_next       = PH_ERR;
          end
        end
        PH_ERR: begin
          error_byte_next    = head.data;
          running_crc_next   = crc_upd;
          param_counter_next = '0;
          phase_next         = (param_count == '0) ? PH_CRC1 : PH_PARAM;
        end
        PH_PARAM: begin
          running_crc_next   = crc_upd;
          res_valid          = 1'b1;
          res_kind           = KIND_PARAM;
          res_pbyte          = head.data;
          res_pidx           = param_counter;
          param_counter_next = cnt_inc;
          if (cnt_inc >= param_count) begin
            phase_next = PH_CRC1;
          end
        end
        PH_CRC1: begin
          crc_low_byte_next = head.data;
          phase_next        = PH_CRC2;
        end
        PH_CRC2: begin
          finish_now = 1'b1;
          if ({head.data, crc_low_byte} != running_crc) begin
            res_reason = RSN_CRC;
          end else begin
            res_kind = KIND_ACCEPT;
          end
        end
        default: begin
          phase_next         = PH_H0;
          running_crc_next   = '0;
          param_counter_next = '0;
          received_id_next   = '0;
          error_byte_next    = '0;
          crc_low_byte_next  = '0;
        end
      endcase
    end

    // Packet end: report and return to hunting
    if (finish_now) begin
      res_valid          = 1'b1;
      phase_next         = PH_H0;
      running_crc_next   = '0;
      param_counter_next = '0;
      received_id_next   = '0;
      error_byte_next    = '0;
      crc_low_byte_next  = '0;
    end
  end

  // Packet state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_H0;
      running_crc   <= '0;
      param_counter <= '0;
      received_id   <= '0;
      error_byte    <= '0;
      crc_low_byte  <= '0;
    end else if (pop) begin
      phase         <= phase_next;
      running_crc   <= running_crc_next;
      param_counter <= param_counter_next;
      received_id   <= received_id_next;
      error_byte    <= error_byte_next;
      crc_low_byte  <= crc_low_byte_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && res_valid) begin
      kind          <= res_kind;
      param_byte    <= res_pbyte;
      param_index   <= res_pidx;
      sender_id     <= res_sid;
      device_error  <= res_err;
      reject_reason <= res_reason;
    end
  end

`ifndef SYNTH
  a_reason_matches_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((kind == KIND_REJECT) == (reject_reason != RSN_NONE)))
    else $error("reject reason does not match result kind");
  a_phase_range: assert property (@(posedge clk) disable iff (rst) phase <= PH_CRC2)
    else $error("phase out of range");
  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    (pop && finish_now) |=> (phase == PH_H0 && running_crc == '0))
    else $error("packet end did not return to hunting");
`endif

endmodule

`default_nettype wire

// ===== design/servo_status_packet_receiver_core.sv =====
// Top level of the servo status packet receiver: front classifier, queue, back parser.
// Uses sspr_pkg, sspr_front, sspr_queue and sspr_back.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------------------
//   in       | in_valid / in_ready    | action, rx_byte
//   out      | out_valid / out_ready  | kind, param_byte, param_index, sender_id,
//            |                        | device_error, reject_reason
//   cfg      | cfg_we (no wait)       | cfg_index, cfg_data
//
// One beat per cycle sustained unless out_ready stalls the outputs; the CRC byte step is
// combinational. A taken beat goes to a queue entry, then to the result register.
// Reset (rst, synchronous) empties the queue and returns the parser to header hunting.
// Output stalls back up into the two-entry queue; in_ready drops only when it is full.
`timescale 1ns / 1ps
`default_nettype none

module servo_status_packet_receiver_core
  import sspr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        action,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       kind,
  output logic [7:0]       param_byte,
  output logic [15:0]      param_index,
  output logic [7:0]       sender_id,
  output logic [7:0]       device_error,
  output logic [2:0]       reject_reason
);

  item_t       front_item;
  item_t       head;
  logic [15:0] param_count;
  logic        q_full;
  logic        q_avail;
  logic        q_pop;
  logic        q_push;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  sspr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .action      (action),
    .rx_byte     (rx_byte),
    .item        (front_item),
    .param_count (param_count)
  );

  sspr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .head      (head)
  );

  sspr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .param_count   (param_count),
    .avail         (q_avail),
    .head          (head),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .param_byte    (param_byte),
    .param_index   (param_index),
    .sender_id     (sender_id),
    .device_error  (device_error),
    .reject_reason (reject_reason)
  );

endmodule

`default_nettype wire
